FILE: hw/rtl/distance_vector_route_table_core_assert.svh
// Assertion macros used by the route table engine.
// Every macro samples on the rising edge of clock and is quiet while reset is high.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_ASSERT_SVH

// The property must hold in the same cycle.
`define DVRT_ASSERT_NOW(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// If the condition holds in one cycle, the consequence must hold in the next cycle.
`define DVRT_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   localparam logic [15:0] COST_MAX = 16'hFFFF;

   // Function codes on the request side.
   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_HEADER = 2'd1;
   localparam logic [1:0] FUNC_ENTRY  = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_FOUND   = 3'd0;
   localparam logic [2:0] ST_NOROUTE = 3'd1;
   localparam logic [2:0] ST_HEADER  = 3'd2;
   localparam logic [2:0] ST_ENTRY   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_HEADER = 2'd1,
      OP_ENTRY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // A classified command as it travels from the front end to the table engine.
   typedef struct packed {
      op_type      op;
      logic        own;      // entry names this node's own address
      logic [31:0] address;
      logic [15:0] cost;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] next_hop;
      logic [15:0] route_cost;
   } rsp_type;

   // Handshake between the command queue and its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

FILE: hw/rtl/distance_vector_route_table_core.sv
// Distance-vector route table. Each beat pushed on the request side is a lookup, an advert
// header or an advert entry; each produces exactly one response beat, in order. The front end
// registers and classifies a beat and hands it to a two-deep command queue, so up to three
// beats can be taken while the table engine is busy; for a lookup, a header or an entry not
// naming this node, the engine then walks all TABLE_ENTRIES slots, one slot per clock, to
// find the matching route and the lowest free slot. It applies the update once the result
// queue has room, and takes no new beat until it has answered the last, so the table walk
// sets the sustained rate. Responses wait in a two-deep result queue, so a stalled consumer
// does not stop the engine until that queue fills. The table is empty after reset with no
// clearing pass. The own-address register may be written only while the block is idle.
module distance_vector_route_table_core
   import dvrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_address,
   input  logic [15:0] req_cost,
   // Response channel.
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_next_hop,
   output logic [15:0] rsp_route_cost,
   // Configuration: this node's own address.
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata
);

   // The own address is compared in the front end, so an advert entry that names this
   // node is marked before it reaches the table engine.
   logic [31:0] own_address_ff, own_address_in;

   q_stat_type q_stat;
   logic       q_push, q_pop;
   cmd_type    q_wr_cmd, q_rd_cmd;
   rsp_type    rsp;

   assign own_address_in = csr_wen ? csr_wdata : own_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   dvrt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_func    (req_func),
      .req_address (req_address),
      .req_cost    (req_cost),
      .own_address (own_address_ff),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_cmd       (q_wr_cmd)
   );

   dvrt_cmdq u_cmdq (
      .clock  (clock),
      .reset  (reset),
      .wr     (q_push),
      .wr_cmd (q_wr_cmd),
      .rd     (q_pop),
      .rd_cmd (q_rd_cmd),
      .stat   (q_stat)
   );

   // The engine owns the table and the advert context (last neighbour, its link cost and
   // whether its header refreshed a direct route).
   dvrt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .q_cmd  (q_rd_cmd),
      .q_pop  (q_pop),
      .empty  (empty),
      .pop    (pop),
      .rsp    (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_next_hop   = rsp.next_hop;
   assign rsp_route_cost = rsp.route_cost;

endmodule

FILE: hw/rtl/dvrt_front.sv
module dvrt_front
   import dvrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_address,
   input  logic [15:0] req_cost,
   input  logic [31:0] own_address,
   input  q_stat_type  q_stat,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   // The holding stage drains into the queue whenever the queue has room.
   assign q_push = valid_ff && !q_stat.full;
   assign q_cmd  = cmd_ff;
   assign full   = valid_ff && q_stat.full;
   assign accept = push && !full;

   always_comb begin
      cmd_in         = cmd_ff;
      cmd_in.address = req_address;
      cmd_in.cost    = req_cost;
      cmd_in.own     = (req_address == own_address);
      case (req_func)
         FUNC_LOOKUP: cmd_in.op = OP_LOOKUP;
         FUNC_HEADER: cmd_in.op = OP_HEADER;
         FUNC_ENTRY:  cmd_in.op = OP_ENTRY;
         default:     cmd_in.op = OP_NONE;
      endcase
      if (!accept) begin
         cmd_in = cmd_ff;
      end
      valid_in = accept || (valid_ff && !q_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

FILE: hw/rtl/dvrt_cmdq.sv
module dvrt_cmdq
   import dvrt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr,
   input  cmd_type    wr_cmd,
   input  logic       rd,
   output cmd_type    rd_cmd,
   output q_stat_type stat
);

   cmd_type               slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_wr, do_rd;

   assign stat.full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr      = wr && !stat.full;
   assign do_rd      = rd && !stat.empty;
   assign rd_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: hw/rtl/dvrt_back.sv
module dvrt_back
   import dvrt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_stat_type q_stat,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp
);

   `include "distance_vector_route_table_core_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   // Route table.
   logic        valid_ff [TABLE_ENTRIES];
   logic [31:0] dest_ff  [TABLE_ENTRIES];
   logic [31:0] hop_ff   [TABLE_ENTRIES];
   logic [15:0] cost_ff  [TABLE_ENTRIES];

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [31:0]        hit_hop_ff, hit_hop_in;
   logic [15:0]        hit_cost_ff, hit_cost_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [15:0]        sum_ff, sum_in;

   // Advert context left behind by the last header.
   logic [31:0] nbr_ff, nbr_in;
   logic [15:0] link_ff, link_in;
   logic        refr_ff, refr_in;

   // Result queue.
   rsp_type               rq_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] rq_wr_ff, rq_wr_in;
   logic [RSPQ_PTR_W-1:0] rq_rd_ff, rq_rd_in;
   logic [RSPQ_CNT_W-1:0] rq_cnt_ff, rq_cnt_in;

   logic             rq_space, rq_pop, apply_go;
   logic             scan_match, scan_last;
   logic [16:0]      sum_wide;
   rsp_type          res;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0]      wr_hop;
   logic [15:0]      wr_cost;

   assign rq_space   = (rq_cnt_ff != RSPQ_CNT_W'(RSPQ_DEPTH));
   assign empty      = (rq_cnt_ff == '0);
   assign rq_pop     = pop && !empty;
   assign rsp        = rq_ff[rq_rd_ff];
   assign apply_go   = (state_ff == S_APPLY) && rq_space;
   assign q_pop      = (state_ff == S_IDLE) && !q_stat.empty;
   assign scan_match = valid_ff[idx_ff] && (dest_ff[idx_ff] == cmd_ff.address);
   assign scan_last  = (idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sum_wide   = {1'b0, q_cmd.cost} + {1'b0, link_ff};

   // Sequencer: take a command, walk the table once (not for an own entry or unknown code), then apply and answer.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_hop_in  = hit_hop_ff;
      hit_cost_in = hit_cost_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      sum_in      = sum_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               cmd_in  = q_cmd;
               idx_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               sum_in  = sum_wide[16] ? COST_MAX : sum_wide[15:0];
               if (q_cmd.op inside {OP_LOOKUP, OP_HEADER} ||
                   (q_cmd.op == OP_ENTRY && !q_cmd.own)) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_SCAN: begin
            if (scan_match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = idx_ff;
               hit_hop_in  = hop_ff[idx_ff];
               hit_cost_in = cost_ff[idx_ff];
            end
            if (!valid_ff[idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (scan_last) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (rq_space) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Decision for the command once the walk is done.
   always_comb begin
      res.status     = ST_NOROUTE;
      res.next_hop   = '0;
      res.route_cost = '0;
      wr_en   = 1'b0;
      wr_idx  = hit_idx_ff;
      wr_hop  = hit_hop_ff;
      wr_cost = hit_cost_ff;
      nbr_in  = nbr_ff;
      link_in = link_ff;
      refr_in = refr_ff;
      case (cmd_ff.op)
         OP_LOOKUP: begin
            if (hit_ff) begin
               res.status     = ST_FOUND;
               res.next_hop   = hit_hop_ff;
               res.route_cost = hit_cost_ff;
            end
         end
         OP_HEADER: begin
            res.status = ST_HEADER;
            nbr_in     = cmd_ff.address;
            link_in    = cmd_ff.cost;
            refr_in    = 1'b0;
            if (hit_ff) begin
               if (hit_hop_ff == cmd_ff.address) begin
                  wr_en   = 1'b1;
                  wr_cost = cmd_ff.cost;
                  refr_in = 1'b1;
               end
            end else if (free_ff) begin
               wr_en   = 1'b1;
               wr_idx  = free_idx_ff;
               wr_hop  = cmd_ff.address;
               wr_cost = cmd_ff.cost;
            end else begin
               res.status = ST_FULL;
            end
         end
         OP_ENTRY: begin
            res.status = ST_ENTRY;
            if (!cmd_ff.own) begin
               if (hit_ff) begin
                  if (refr_ff && hit_hop_ff == nbr_ff) begin
                     wr_en   = 1'b1;
                     wr_cost = sum_ff;
                  end else if (sum_ff < hit_cost_ff) begin
                     wr_en   = 1'b1;
                     wr_cost = sum_ff;
                     wr_hop  = nbr_ff;
                  end
               end else if (free_ff) begin
                  wr_en   = 1'b1;
                  wr_idx  = free_idx_ff;
                  wr_hop  = nbr_ff;
                  wr_cost = sum_ff;
               end else begin
                  res.status = ST_FULL;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rq_wr_in  = apply_go ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (apply_go && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop && !apply_go) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         nbr_ff    <= '0;
         link_ff   <= '0;
         refr_ff   <= 1'b0;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
         if (apply_go) begin
            nbr_ff  <= nbr_in;
            link_ff <= link_in;
            refr_ff <= refr_in;
            if (wr_en) begin
               valid_ff[wr_idx] <= 1'b1;
            end
         end
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_hop_ff  <= hit_hop_in;
      hit_cost_ff <= hit_cost_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      sum_ff      <= sum_in;
      if (apply_go) begin
         rq_ff[rq_wr_ff] <= res;
         if (wr_en) begin
            dest_ff[wr_idx] <= cmd_ff.address;
            hop_ff[wr_idx]  <= wr_hop;
            cost_ff[wr_idx] <= wr_cost;
         end
      end
   end

   `DVRT_ASSERT_NOW(a_rq_bound, rq_cnt_ff <= RSPQ_CNT_W'(RSPQ_DEPTH), "result queue overflow")
   `DVRT_ASSERT_NOW(a_hit_live, !(state_ff == S_APPLY && hit_ff) || (valid_ff[hit_idx_ff] && dest_ff[hit_idx_ff] == cmd_ff.address), "matched route changed before apply")
   `DVRT_ASSERT_NOW(a_free_live, !(state_ff == S_APPLY && free_ff) || !valid_ff[free_idx_ff], "free slot is occupied at apply")
   `DVRT_ASSERT_NEXT(a_apply_done, apply_go, state_ff == S_IDLE && !empty, "apply did not post a result")

endmodule
